// ===== rtl/svm_pkg.sv =====
`timescale 1ns / 1ps

package svm_pkg;

  // Field and register widths fixed by the programming model.
  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 13;
  localparam int VOL_W    = 7;
  localparam int REG_W    = 3;
  localparam int LEN_REGS = 3;

  // Volume limits.
  localparam logic [VOL_W-1:0] VOL_MAX   = 7'd100;
  localparam logic [VOL_W-1:0] VOL_RESET = 7'd80;

  // Configuration register indexes.
  localparam logic [REG_W-1:0] REG_VOLUME = 3'd0;
  localparam logic [REG_W-1:0] REG_MUTED  = 3'd1;
  localparam logic [REG_W-1:0] REG_LEN_A  = 3'd2;
  localparam logic [REG_W-1:0] REG_LEN_B  = 3'd3;
  localparam logic [REG_W-1:0] REG_LEN_C  = 3'd4;

  // Item kinds.
  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_TRIGGER = 2'd1;
  localparam logic [1:0] MODE_LOAD    = 2'd2;

  // Division by 100 as a multiplication by ceil(2^32 / 100) and a shift.
  localparam int                 RECIP_SHIFT = 32;
  localparam int                 RECIP_W     = 26;
  localparam logic [RECIP_W-1:0] RECIP_100   = 26'd42949673;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VOICE,
    ST_DRAIN,
    ST_GAIN,
    ST_ABS,
    ST_RECIP,
    ST_OUT
  } state_t;

  // Operations of the shared arithmetic unit.
  typedef enum logic [2:0] {
    ALU_HOLD,
    ALU_CLEAR,
    ALU_ACC,
    ALU_GAIN,
    ALU_ABS,
    ALU_RECIP
  } alu_op_t;

endpackage

// ===== rtl/svm_sample_mem.sv =====
`timescale 1ns / 1ps

module svm_sample_mem #(
  parameter int DEPTH = 12288,
  parameter int AW    = 14
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [svm_pkg::SAMPLE_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [svm_pkg::SAMPLE_W-1:0] rd_data
);
  import svm_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];

  // Single write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/svm_alu.sv =====
`timescale 1ns / 1ps

module svm_alu #(
  parameter int SUM_W = 20
) (
  input  logic                                clk,
  input  svm_pkg::alu_op_t                    op,
  input  logic signed [svm_pkg::SAMPLE_W-1:0] sample,
  input  logic [svm_pkg::VOL_W-1:0]           volume,
  output logic signed [svm_pkg::SAMPLE_W-1:0] result
);
  import svm_pkg::*;

  localparam int PROD_W = SUM_W + VOL_W + 1;
  localparam int MA_W   = PROD_W + 1;
  localparam int MB_W   = RECIP_W + 1;
  localparam int MP_W   = MA_W + MB_W;
  localparam int Q_W    = MP_W - RECIP_SHIFT;

  localparam logic signed [PROD_W-1:0] SAT_HI = {{(PROD_W-15){1'b0}}, 15'h7fff};
  localparam logic signed [PROD_W-1:0] SAT_LO = {{(PROD_W-15){1'b1}}, 15'h0000};

  logic signed [PROD_W-1:0] acc;
  logic                     neg;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [MP_W-1:0]   prod;
  logic signed [PROD_W-1:0] sval;

  // One multiplier serves both the gain and the reciprocal step.
  always_comb begin
    if (op == ALU_GAIN) begin
      mul_a = {{(MA_W-SUM_W){acc[SUM_W-1]}}, acc[SUM_W-1:0]};
      mul_b = {{(MB_W-VOL_W){1'b0}}, volume};
    end else begin
      mul_a = {1'b0, acc};
      mul_b = {1'b0, RECIP_100};
    end
  end

  assign prod = mul_a * mul_b;

  // Accumulator. The magnitude stays well below 2^30, so the ceiling
  // reciprocal gives the exact truncated quotient without correction.
  always_ff @(posedge clk) begin
    case (op)
      ALU_CLEAR: begin
        acc <= '0;
        neg <= 1'b0;
      end
      ALU_ACC: begin
        acc <= acc + {{(PROD_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
      end
      ALU_GAIN: begin
        acc <= prod[PROD_W-1:0];
      end
      ALU_ABS: begin
        neg <= acc[PROD_W-1];
        acc <= acc[PROD_W-1] ? -acc : acc;
      end
      ALU_RECIP: begin
        acc <= {{(PROD_W-Q_W){1'b0}}, prod[MP_W-1:RECIP_SHIFT]};
      end
      default: begin
      end
    endcase
  end

  // Restore the sign and saturate to 16 bits.
  always_comb begin
    sval = neg ? -acc : acc;
    if (sval > SAT_HI) begin
      result = SAT_HI[SAMPLE_W-1:0];
    end else if (sval < SAT_LO) begin
      result = SAT_LO[SAMPLE_W-1:0];
    end else begin
      result = sval[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== rtl/sample_voice_mixer.sv =====
`timescale 1ns / 1ps
// Tick items visit each voice in turn through the single sample memory read port, then run
// gain, sign, reciprocal and output steps in the shared arithmetic unit. The output step
// waits while a held result is not taken; no new item is accepted until the tick is done.
// Trigger and load items are accepted in the idle state and give no result.
// Synchronous reset clears voices, volume (to 80), mute and lengths; sample memory is not cleared.
module sample_voice_mixer #(
  parameter int VOICES      = 6,
  parameter int SOUND_DEPTH = 4096,
  parameter int SOUNDS      = 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // sound_id[1:0], load_address[13:2], load_value[29:14], zero fill [31:30]
  input  logic [31:0]                  s_tdata,
  // mode[1:0]
  input  logic [1:0]                   s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // mixed_sample[15:0]
  output logic [15:0]                  m_tdata,
  input  logic                         cfg_wr_en,
  input  logic [svm_pkg::REG_W-1:0]    cfg_index,
  input  logic [svm_pkg::LEN_W-1:0]    cfg_data
);
  import svm_pkg::*;

  localparam int VI_W      = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int POS_W     = $clog2(SOUND_DEPTH);
  localparam int CMP_W     = (POS_W + 1 > LEN_W) ? POS_W + 1 : LEN_W;
  localparam int MEM_DEPTH = SOUNDS * SOUND_DEPTH;
  localparam int MA_W      = $clog2(MEM_DEPTH);
  localparam int SUM_W     = SAMPLE_W + $clog2(VOICES) + 1;

  // Input fields.
  logic [1:0]          mode;
  logic [1:0]          sound_id;
  logic [11:0]         load_address;
  logic [SAMPLE_W-1:0] load_value;

  assign mode         = s_tuser;
  assign sound_id     = s_tdata[1:0];
  assign load_address = s_tdata[13:2];
  assign load_value   = s_tdata[29:14];

  // Configuration registers.
  logic [VOL_W-1:0] volume;
  logic             muted;
  logic [LEN_W-1:0] len_reg [LEN_REGS];

  // Voice state.
  logic             voice_active [VOICES];
  logic [1:0]       voice_sound  [VOICES];
  logic [POS_W-1:0] voice_pos    [VOICES];

  // Sequencer.
  state_t           state;
  state_t           state_next;
  logic [VI_W-1:0]  vi;
  logic             play_d;
  alu_op_t          alu_op;
  logic             out_load;

  logic                       accept;
  logic                       sid_ok;
  logic [CMP_W-1:0]           addr_ext;
  logic                       load_ok;
  logic [VI_W-1:0]            pick;
  logic [1:0]                 cur_snd;
  logic [POS_W-1:0]           cur_pos;
  logic [POS_W:0]             pos_inc;
  logic [LEN_W-1:0]           cur_len;
  logic                       voice_play;
  logic                       voice_stop;
  logic                       voice_fire;
  logic [MA_W-1:0]            rd_addr;
  logic [MA_W-1:0]            wr_addr;
  logic [SAMPLE_W-1:0]        rd_data;
  logic signed [SAMPLE_W-1:0] alu_result;

  assign accept   = s_tvalid && s_tready;
  assign sid_ok   = ({1'b0, sound_id} < 3'(SOUNDS));
  assign addr_ext = CMP_W'(load_address);
  assign load_ok  = accept && (mode == MODE_LOAD) && sid_ok &&
                    (addr_ext < CMP_W'(SOUND_DEPTH));
  assign wr_addr  = MA_W'(sound_id) * MA_W'(SOUND_DEPTH) + MA_W'(addr_ext[POS_W-1:0]);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      volume <= VOL_RESET;
      muted  <= 1'b0;
      for (int i = 0; i < LEN_REGS; i++) begin
        len_reg[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_VOLUME: volume <= (cfg_data[VOL_W-1:0] > VOL_MAX) ? VOL_MAX : cfg_data[VOL_W-1:0];
        REG_MUTED:  muted <= cfg_data[0];
        REG_LEN_A:  len_reg[0] <= cfg_data;
        REG_LEN_B:  len_reg[1] <= cfg_data;
        REG_LEN_C:  len_reg[2] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Lowest free voice for a trigger; voice 0 when all are busy.
  always_comb begin
    pick = '0;
    for (int v = VOICES - 1; v >= 0; v--) begin
      if (!voice_active[v]) begin
        pick = VI_W'(v);
      end
    end
  end

  // The voice visited in this cycle.
  always_comb begin
    cur_snd = voice_sound[vi];
    cur_pos = voice_pos[vi];
    pos_inc = {1'b0, cur_pos} + 1'b1;
    if ({1'b0, cur_snd} < 3'(LEN_REGS)) begin
      cur_len = len_reg[cur_snd];
    end else begin
      cur_len = '0;
    end
    voice_play = (state == ST_VOICE) && voice_active[vi] && !muted;
    voice_stop = ({1'b0, cur_snd} >= 3'(SOUNDS)) ||
                 (CMP_W'(pos_inc) >= CMP_W'(cur_len)) ||
                 (CMP_W'(pos_inc) >= CMP_W'(SOUND_DEPTH));
    voice_fire = voice_play && !voice_stop;
    rd_addr    = MA_W'(cur_snd) * MA_W'(SOUND_DEPTH) + MA_W'(cur_pos);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (mode == MODE_TICK)) begin
          state_next = ST_VOICE;
        end
      end
      ST_VOICE: begin
        if (vi == VI_W'(VOICES - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_GAIN;
      ST_GAIN:  state_next = ST_ABS;
      ST_ABS:   state_next = ST_RECIP;
      ST_RECIP: state_next = ST_OUT;
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_tready = 1'b0;
    alu_op   = ALU_HOLD;
    out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (accept && (mode == MODE_TICK)) begin
          alu_op = ALU_CLEAR;
        end
      end
      ST_VOICE, ST_DRAIN: begin
        if (play_d) begin
          alu_op = ALU_ACC;
        end
      end
      ST_GAIN:  alu_op = ALU_GAIN;
      ST_ABS:   alu_op = ALU_ABS;
      ST_RECIP: alu_op = ALU_RECIP;
      ST_OUT:   out_load = !m_tvalid || m_tready;
      default: begin
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      vi     <= '0;
      play_d <= 1'b0;
    end else begin
      state  <= state_next;
      play_d <= voice_fire;
      if (state == ST_VOICE) begin
        vi <= vi + 1'b1;
      end else begin
        vi <= '0;
      end
    end
  end

  // Voice updates: trigger items start a voice, ticks advance or stop one.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int v = 0; v < VOICES; v++) begin
        voice_active[v] <= 1'b0;
        voice_sound[v]  <= '0;
        voice_pos[v]    <= '0;
      end
    end else if (accept && (mode == MODE_TRIGGER)) begin
      voice_active[pick] <= 1'b1;
      voice_sound[pick]  <= sid_ok ? sound_id : 2'd0;
      voice_pos[pick]    <= '0;
    end else if (voice_play) begin
      if (voice_stop) begin
        voice_active[vi] <= 1'b0;
      end else begin
        voice_pos[vi] <= pos_inc[POS_W-1:0];
      end
    end
  end

  svm_sample_mem #(
    .DEPTH (MEM_DEPTH),
    .AW    (MA_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (load_ok),
    .wr_addr (wr_addr),
    .wr_data (load_value),
    .rd_en   (voice_fire),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  svm_alu #(
    .SUM_W (SUM_W)
  ) u_alu (
    .clk    (clk),
    .op     (alu_op),
    .sample (rd_data),
    .volume (volume),
    .result (alu_result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= alu_result;
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import svm_pkg::*;

  localparam int VOICES      = 6;
  localparam int DEPTH       = 4096;
  localparam int SOUND_CNT   = 3;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN       = 24;
  localparam int IDLE_LIMIT  = 4000;
  localparam int SCRIPT_LEN  = 24;

  // Item kind with no meaning and the first register index beyond the map.
  localparam logic [1:0]       MODE_UNUSED = 2'd3;
  localparam logic [REG_W-1:0] REG_SPARE   = 3'd5;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [31:0]         s_tdata;
  logic [1:0]          s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [15:0]         m_tdata;
  logic                cfg_wr_en;
  logic [REG_W-1:0]    cfg_index;
  logic [LEN_W-1:0]    cfg_data;

  sample_voice_mixer #(
    .VOICES      (VOICES),
    .SOUND_DEPTH (DEPTH),
    .SOUNDS      (SOUND_CNT)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the mixer state, kept up to date as items are accepted.
  logic [VOL_W-1:0]   volume_reg;
  logic               muted_reg;
  logic [LEN_W-1:0]   sound_len [0:SOUND_CNT-1];
  bit                 voice_on  [0:VOICES-1];
  logic [1:0]         voice_snd [0:VOICES-1];
  logic [11:0]        voice_pos [0:VOICES-1];
  logic signed [15:0] pcm_mem    [0:SOUND_CNT*DEPTH-1];
  bit                 pcm_loaded [0:SOUND_CNT*DEPTH-1];

  logic [15:0] mix_expected [$];
  logic [15:0] mix_head;
  int          fail_count;
  int          idle_cycles;
  bit          calm;
  bit          hold_req;

  // One row of the directed script; mix is only meaningful when known is set.
  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  sid;
    logic [11:0] addr;
    logic [15:0] pcm;
    logic        known;
    logic [15:0] mix;
  } dir_row_t;

  // Played with volume written as 127 (held at 100) and lengths 3, 8191 and 1.
  dir_row_t script [0:SCRIPT_LEN-1] = '{
    '{MODE_TICK,    2'd0, 12'd0,    16'h0000, 1'b1, 16'h0000},
    '{MODE_UNUSED,  2'd3, 12'hfff,  16'hffff, 1'b0, 16'h0000},
    '{MODE_LOAD,    2'd0, 12'd0,    16'h7fff, 1'b0, 16'h0000},
    '{MODE_LOAD,    2'd0, 12'd1,    16'h8000, 1'b0, 16'h0000},
    '{MODE_LOAD,    2'd3, 12'd0,    16'h04d2, 1'b0, 16'h0000},
    '{MODE_LOAD,    2'd1, 12'd0,    16'h7fff, 1'b0, 16'h0000},
    '{MODE_LOAD,    2'd1, 12'd1,    16'h7fff, 1'b0, 16'h0000},
    '{MODE_TRIGGER, 2'd0, 12'd0,    16'h0000, 1'b0, 16'h0000},
    '{MODE_TRIGGER, 2'd3, 12'd0,    16'h0000, 1'b0, 16'h0000},
    '{MODE_TRIGGER, 2'd1, 12'd0,    16'h0000, 1'b0, 16'h0000},
    '{MODE_TRIGGER, 2'd2, 12'd0,    16'h0000, 1'b0, 16'h0000},
    '{MODE_TICK,    2'd0, 12'd0,    16'h0000, 1'b1, 16'h7fff},
    '{MODE_TICK,    2'd0, 12'd0,    16'h0000, 1'b1, 16'h8000},
    '{MODE_LOAD,    2'd1, 12'd2,    16'h0001, 1'b0, 16'h0000},
    '{MODE_TICK,    2'd0, 12'd0,    16'h0000, 1'b1, 16'h0001},
    '{MODE_LOAD,    2'd1, 12'd3,    16'hfffb, 1'b0, 16'h0000},
    '{MODE_TRIGGER, 2'd0, 12'd0,    16'h0000, 1'b0, 16'h0000},
    '{MODE_TRIGGER, 2'd0, 12'd0,    16'h0000, 1'b0, 16'h0000},
    '{MODE_TRIGGER, 2'd0, 12'd0,    16'h0000, 1'b0, 16'h0000},
    '{MODE_TRIGGER, 2'd0, 12'd0,    16'h0000, 1'b0, 16'h0000},
    '{MODE_TRIGGER, 2'd0, 12'd0,    16'h0000, 1'b0, 16'h0000},
    '{MODE_TRIGGER, 2'd2, 12'd0,    16'h0000, 1'b0, 16'h0000},
    '{MODE_TICK,    2'd0, 12'd0,    16'h0000, 1'b1, 16'h7fff},
    '{MODE_LOAD,    2'd2, 12'hfff,  16'hffff, 1'b0, 16'h0000}
  };

  // Effective frame count of a sound, capped at the memory depth.
  function automatic int play_length(input logic [1:0] snd);
    int n;
    n = (snd < SOUND_CNT) ? int'(sound_len[snd]) : 0;
    return (n > DEPTH) ? DEPTH : n;
  endfunction

  // One voice's contribution to a tick, advancing or stopping it.
  function automatic int voice_play(input int v);
    int snd;
    int pos;
    if (!voice_on[v] || muted_reg) return 0;
    snd = voice_snd[v];
    pos = voice_pos[v];
    if (snd >= SOUND_CNT || pos + 1 >= play_length(voice_snd[v])) begin
      voice_on[v] = 1'b0;
      return 0;
    end
    voice_pos[v] = 12'(pos + 1);
    return pcm_mem[snd * DEPTH + pos];
  endfunction

  // Sum of all voices, scaled by the volume percentage and clipped to 16 bits.
  function automatic logic [15:0] mix_tick();
    int sum;
    sum = 0;
    for (int v = 0; v < VOICES; v++) sum += voice_play(v);
    sum = (sum * int'(volume_reg)) / 100;
    if (sum > 32767) sum = 32767;
    if (sum < -32768) sum = -32768;
    return sum[15:0];
  endfunction

  // A trigger takes the lowest free voice, or voice 0 when all are busy.
  function automatic void claim_voice(input logic [1:0] sid);
    int pick;
    pick = 0;
    for (int v = VOICES - 1; v >= 0; v--) if (!voice_on[v]) pick = v;
    voice_snd[pick] = (sid < SOUND_CNT) ? sid : 2'd0;
    voice_pos[pick] = '0;
    voice_on[pick]  = 1'b1;
  endfunction

  function automatic void apply_register(input logic [REG_W-1:0] idx,
                                         input logic [LEN_W-1:0] data);
    case (idx)
      REG_VOLUME: volume_reg = (data[VOL_W-1:0] > VOL_MAX) ? VOL_MAX : data[VOL_W-1:0];
      REG_MUTED:  muted_reg = data[0];
      REG_LEN_A:  sound_len[0] = data;
      REG_LEN_B:  sound_len[1] = data;
      REG_LEN_C:  sound_len[2] = data;
      default: ;
    endcase
  endfunction

  // Offer one item, wait for it to be taken, then update the mirror.
  task automatic send_item(input logic [1:0] mode, input logic [1:0] sid,
                           input logic [11:0] addr, input logic [15:0] pcm,
                           input logic known, input logic [15:0] mix);
    logic [15:0] predicted;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {2'b00, pcm, addr, sid};
    do @(posedge clk); while (!s_tready);
    case (mode)
      MODE_TICK: begin
        predicted = mix_tick();
        mix_expected.push_back(known ? mix : predicted);
      end
      MODE_TRIGGER: claim_voice(sid);
      MODE_LOAD: begin
        if (sid < SOUND_CNT) begin
          pcm_mem[sid * DEPTH + addr]    = pcm;
          pcm_loaded[sid * DEPTH + addr] = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // Drive one register write; the caller lowers the enable afterwards.
  task automatic put_reg(input logic [REG_W-1:0] idx, input logic [LEN_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_register(idx, data);
  endtask

  task automatic write_config(input logic [LEN_W-1:0] vol, input logic [LEN_W-1:0] mute,
                              input logic [LEN_W-1:0] len_a, input logic [LEN_W-1:0] len_b,
                              input logic [LEN_W-1:0] len_c);
    put_reg(REG_VOLUME, vol);
    put_reg(REG_MUTED, mute);
    put_reg(REG_LEN_A, len_a);
    put_reg(REG_LEN_B, len_b);
    put_reg(REG_LEN_C, len_c);
    // A write to an index beyond the map must change nothing.
    put_reg(REG_SPARE + REG_W'($urandom_range(0, 2)), LEN_W'($urandom));
    cfg_wr_en <= 1'b0;
  endtask

  // Stop offering, let every outstanding frame arrive, then allow the pipeline to empty.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (mix_expected.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Random traffic: mostly loads, triggers and ticks, with a few unused items mixed in.
  task automatic run_phase(input int item_count);
    int sent;
    int pick;
    sent = 0;
    while (sent < item_count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // Fill any sample that an active voice is about to play but that was never loaded.
        for (int v = 0; v < VOICES; v++) begin
          if (voice_on[v] && !muted_reg && voice_pos[v] + 1 < play_length(voice_snd[v]) &&
              !pcm_loaded[voice_snd[v] * DEPTH + voice_pos[v]]) begin
            send_item(MODE_LOAD, voice_snd[v], voice_pos[v], 16'($urandom), 1'b0, '0);
            sent++;
          end
        end
        send_item(MODE_TICK, 2'($urandom), 12'($urandom), 16'($urandom), 1'b0, '0);
        sent++;
      end else if (pick < 58) begin
        send_item(MODE_TRIGGER, 2'($urandom_range(0, 3)), 12'($urandom), 16'($urandom),
                  1'b0, '0);
        sent++;
      end else if (pick < 95) begin
        send_item(MODE_LOAD,
                  ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
                  ($urandom_range(0, 6) == 0) ? 12'($urandom) : 12'($urandom_range(0, 47)),
                  16'($urandom), 1'b0, '0);
        sent++;
      end else begin
        send_item(MODE_UNUSED, 2'($urandom), 12'($urandom), 16'($urandom), 1'b0, '0);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, one long hold-off on request, none once calm.
  initial begin
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (calm || $urandom_range(0, 5) != 0) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  // Compare every accepted frame with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (mix_expected.size() == 0) begin
        $error("mixed_sample: expected none, got %0d", $signed(m_tdata));
        fail_count++;
      end else begin
        mix_head = mix_expected.pop_front();
        if (m_tdata !== mix_head) begin
          $error("mixed_sample: expected %0d, got %0d", $signed(mix_head), $signed(m_tdata));
          fail_count++;
        end
      end
    end
  end

  // Give up if nothing moves on any port for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= MODE_TICK;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_VOLUME;
    cfg_data  <= '0;
    fail_count  = 0;
    idle_cycles = 0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    volume_reg  = VOL_RESET;
    muted_reg   = 1'b0;
    for (int s = 0; s < SOUND_CNT; s++) sound_len[s] = '0;
    for (int v = 0; v < VOICES; v++) begin
      voice_on[v]  = 1'b0;
      voice_snd[v] = '0;
      voice_pos[v] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part: over-range volume and length, a length of one.
    write_config(13'd127, 13'd0, 13'd3, 13'd8191, 13'd1);
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      send_item(script[i].mode, script[i].sid, script[i].addr, script[i].pcm,
                script[i].known, script[i].mix);
    end

    settle();
    write_config(13'd57, 13'd0, 13'd12, 13'd30, 13'd5);
    run_phase(190);

    // The receiver holds off at the start of this phase so that the input backs up.
    settle();
    hold_req = 1'b1;
    write_config(13'd100, 13'd0, 13'd2, 13'd0, 13'd4096);
    run_phase(190);

    settle();
    write_config(13'd0, 13'd0, 13'd20, 13'd20, 13'd20);
    run_phase(190);

    settle();
    write_config(13'd33, 13'd1, 13'd16, 13'd9, 13'd3);
    run_phase(150);

    settle();
    write_config(13'd64, 13'd0, 13'd8191, 13'd6, 13'd1);
    run_phase(190);

    settle();
    calm = 1'b1;
    write_config(13'd91, 13'd0, 13'd25, 13'd40, 13'd8);
    run_phase(200);

    settle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
